// File: rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// shared types, widths and codes of the rgb reflectance sequencer
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int READINGS  = 8;
  localparam int SAMPLE_W  = 10;
  localparam int CAL_W     = 10;
  localparam int SETTLE_W  = 16;
  localparam int SUM_W     = 16;
  localparam int LEFT_W    = 7;
  localparam int LEVEL_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam int NUM_W     = 18;
  localparam int DEN_W     = 10;
  localparam int QUOT_W    = 10;
  localparam int DSH_W     = DEN_W + QUOT_W - 1;
  localparam int STEP_W    = $clog2(QUOT_W + 1);

  localparam logic [LEVEL_W-1:0] FULL_SCALE   = LEVEL_W'(255);
  localparam logic [LEFT_W-1:0]  LEFT_INIT    = LEFT_W'(READINGS);
  localparam logic [STEP_W-1:0]  DIV_STEPS    = STEP_W'(QUOT_W);

  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_R   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_R  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_G   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_G  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_B   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_B  = 3'd6;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT_R = 3'd1,
    PH_READ_R = 3'd2,
    PH_WAIT_G = 3'd3,
    PH_READ_G = 3'd4,
    PH_WAIT_B = 3'd5,
    PH_READ_B = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_AVG,
    BK_NORM
  } back_state_t;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_START,
    KIND_ABORT
  } kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    kind_t               kind;
  } item_t;

  typedef struct packed {
    logic               led_red;
    logic               led_green;
    logic               led_blue;
    logic               done_res;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
  } result_t;

  typedef struct packed {
    logic [SETTLE_W-1:0]       settle_ticks;
    logic [2:0][CAL_W-1:0]     cal_low;
    logic [2:0][CAL_W-1:0]     cal_high;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/rrs_front.sv
// ----------------------------------------------------------------------------
// rrs_front
// accepts ticks, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module rrs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [rrs_pkg::SAMPLE_W-1:0]  in_adc_sample,
  input  logic                          in_start_req,
  input  logic                          in_abort,
  output logic                          q_valid,
  output rrs_pkg::item_t                q_item,
  input  logic                          q_pop
);

  rrs_pkg::item_t              mem_r [rrs_pkg::QDEPTH];
  rrs_pkg::item_t              item_in;
  logic [rrs_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [rrs_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [rrs_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        wr_en;
  logic                        rd_en;

  always_comb begin
    item_in.sample = in_adc_sample;
    if (in_abort) begin
      item_in.kind = rrs_pkg::KIND_ABORT;
    end else if (in_start_req) begin
      item_in.kind = rrs_pkg::KIND_START;
    end else begin
      item_in.kind = rrs_pkg::KIND_PLAIN;
    end
  end

  assign full    = (cnt_r == rrs_pkg::QCNT_W'(rrs_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// File: rtl/rrs_div.sv
// ----------------------------------------------------------------------------
// rrs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rrs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rrs_pkg::div_req_t req,
  output rrs_pkg::div_rsp_t rsp
);

  logic [rrs_pkg::NUM_W-1:0]  rem_r, rem_nxt;
  logic [rrs_pkg::DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [rrs_pkg::QUOT_W-1:0] quot_r, quot_nxt;
  logic [rrs_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;
  logic                       ge;

  assign ge = (rrs_pkg::DSH_W'(rem_r) >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.num;
      dsh_nxt  = {req.den, (rrs_pkg::QUOT_W-1)'(0)};
      quot_nxt = '0;
      cnt_nxt  = rrs_pkg::DIV_STEPS;
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_nxt = rem_r - rrs_pkg::NUM_W'(dsh_r);
      end
      quot_nxt = {quot_r[rrs_pkg::QUOT_W-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == rrs_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// File: rtl/rrs_back.sv
// ----------------------------------------------------------------------------
// rrs_back
// led sequencer: settle, accumulate, average and calibrate each channel
// ----------------------------------------------------------------------------
module rrs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rrs_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  rrs_pkg::item_t    q_item,
  output logic              q_pop,
  output logic              res_valid,
  output rrs_pkg::result_t  res,
  input  logic              res_pop
);

  rrs_pkg::back_state_t          state_r, state_nxt;
  rrs_pkg::phase_t               phase_r, phase_nxt;
  rrs_pkg::item_t                item_r;
  logic [rrs_pkg::SETTLE_W-1:0]  settle_r, settle_nxt;
  logic [rrs_pkg::LEFT_W-1:0]    left_r, left_nxt;
  logic [rrs_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [rrs_pkg::LEVEL_W-1:0]   red_r, red_nxt;
  logic [rrs_pkg::LEVEL_W-1:0]   green_r, green_nxt;
  logic [rrs_pkg::LEVEL_W-1:0]   blue_r, blue_nxt;
  logic [rrs_pkg::CAL_W-1:0]     avg_r, avg_nxt;
  logic [1:0]                    ch_r, ch_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rrs_pkg::result_t              out_res_r, out_res_nxt;

  rrs_pkg::div_req_t             div_req;
  rrs_pkg::div_rsp_t             div_rsp;

  logic                          take;
  logic                          fin_read;
  logic                          res_load;
  logic [rrs_pkg::CAL_W-1:0]     lo_sel, hi_sel;
  logic [rrs_pkg::CAL_W-1:0]     x_clamp, diff;
  logic [rrs_pkg::SETTLE_W:0]    cnt_inc;
  logic [rrs_pkg::LEVEL_W-1:0]   lvl_val;
  logic                          lvl_we;

  rrs_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign take  = (state_r == rrs_pkg::BK_IDLE) && q_valid && !out_valid_r;
  assign q_pop = take;

  always_comb begin
    fin_read = (item_r.kind != rrs_pkg::KIND_ABORT) &&
               (phase_r inside {rrs_pkg::PH_READ_R, rrs_pkg::PH_READ_G,
                                rrs_pkg::PH_READ_B}) &&
               (left_r == rrs_pkg::LEFT_W'(1));
  end

  always_comb begin
    case (ch_r)
      rrs_pkg::CH_RED: begin
        lo_sel = cfg.cal_low[0];
        hi_sel = cfg.cal_high[0];
      end
      rrs_pkg::CH_GREEN: begin
        lo_sel = cfg.cal_low[1];
        hi_sel = cfg.cal_high[1];
      end
      default: begin
        lo_sel = cfg.cal_low[2];
        hi_sel = cfg.cal_high[2];
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrs_pkg::BK_IDLE: begin
        if (take) begin
          state_nxt = rrs_pkg::BK_EXEC;
        end
      end
      rrs_pkg::BK_EXEC: begin
        state_nxt = fin_read ? rrs_pkg::BK_AVG : rrs_pkg::BK_IDLE;
      end
      rrs_pkg::BK_AVG: begin
        state_nxt = (hi_sel <= lo_sel) ? rrs_pkg::BK_IDLE : rrs_pkg::BK_NORM;
      end
      rrs_pkg::BK_NORM: begin
        if (div_rsp.done) begin
          state_nxt = rrs_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rrs_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt     = phase_r;
    settle_nxt    = settle_r;
    left_nxt      = left_r;
    sum_nxt       = sum_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    avg_nxt       = avg_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    div_req       = '0;
    res_load      = 1'b0;
    lvl_val       = '0;
    lvl_we        = 1'b0;
    x_clamp       = '0;
    diff          = '0;
    cnt_inc       = {1'b0, settle_r} + 1'b1;

    case (state_r)
      rrs_pkg::BK_EXEC: begin
        if (item_r.kind == rrs_pkg::KIND_ABORT) begin
          phase_nxt  = rrs_pkg::PH_IDLE;
          settle_nxt = '0;
          res_load   = 1'b1;
        end else begin
          case (phase_r)
            rrs_pkg::PH_IDLE: begin
              if (item_r.kind == rrs_pkg::KIND_START) begin
                phase_nxt  = rrs_pkg::PH_WAIT_R;
                settle_nxt = '0;
              end
              res_load = 1'b1;
            end
            rrs_pkg::PH_WAIT_R, rrs_pkg::PH_WAIT_G, rrs_pkg::PH_WAIT_B: begin
              if (cnt_inc >= {1'b0, cfg.settle_ticks}) begin
                case (phase_r)
                  rrs_pkg::PH_WAIT_R: phase_nxt = rrs_pkg::PH_READ_R;
                  rrs_pkg::PH_WAIT_G: phase_nxt = rrs_pkg::PH_READ_G;
                  default:            phase_nxt = rrs_pkg::PH_READ_B;
                endcase
                settle_nxt = '0;
                sum_nxt    = '0;
                left_nxt   = rrs_pkg::LEFT_INIT;
              end else begin
                settle_nxt = cnt_inc[rrs_pkg::SETTLE_W-1:0];
              end
              res_load = 1'b1;
            end
            rrs_pkg::PH_READ_R, rrs_pkg::PH_READ_G, rrs_pkg::PH_READ_B: begin
              sum_nxt  = sum_r + rrs_pkg::SUM_W'(item_r.sample);
              left_nxt = left_r - 1'b1;
              if (fin_read) begin
                avg_nxt    = rrs_pkg::CAL_W'(sum_nxt / rrs_pkg::SUM_W'(rrs_pkg::READINGS));
                settle_nxt = '0;
                case (phase_r)
                  rrs_pkg::PH_READ_R: begin
                    phase_nxt = rrs_pkg::PH_WAIT_G;
                    ch_nxt    = rrs_pkg::CH_RED;
                  end
                  rrs_pkg::PH_READ_G: begin
                    phase_nxt = rrs_pkg::PH_WAIT_B;
                    ch_nxt    = rrs_pkg::CH_GREEN;
                  end
                  default: begin
                    phase_nxt = rrs_pkg::PH_IDLE;
                    ch_nxt    = rrs_pkg::CH_BLUE;
                  end
                endcase
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              phase_nxt = rrs_pkg::PH_IDLE;
              res_load  = 1'b1;
            end
          endcase
        end
      end
      rrs_pkg::BK_AVG: begin
        if (hi_sel <= lo_sel) begin
          lvl_val  = rrs_pkg::FULL_SCALE;
          lvl_we   = 1'b1;
          res_load = 1'b1;
        end else begin
          x_clamp = avg_r;
          if (x_clamp < lo_sel) begin
            x_clamp = lo_sel;
          end
          if (x_clamp > hi_sel) begin
            x_clamp = hi_sel;
          end
          diff          = x_clamp - lo_sel;
          div_req.start = 1'b1;
          div_req.num   = {diff, rrs_pkg::LEVEL_W'(0)} - rrs_pkg::NUM_W'(diff);
          div_req.den   = hi_sel - lo_sel;
        end
      end
      rrs_pkg::BK_NORM: begin
        if (div_rsp.done) begin
          lvl_val  = rrs_pkg::FULL_SCALE - div_rsp.quot[rrs_pkg::LEVEL_W-1:0];
          lvl_we   = 1'b1;
          res_load = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (lvl_we) begin
      case (ch_r)
        rrs_pkg::CH_RED:   red_nxt   = lvl_val;
        rrs_pkg::CH_GREEN: green_nxt = lvl_val;
        default:           blue_nxt  = lvl_val;
      endcase
    end

    if (res_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt           = 1'b1;
      out_res_nxt.led_red     = (phase_nxt == rrs_pkg::PH_WAIT_R) ||
                                (phase_nxt == rrs_pkg::PH_READ_R);
      out_res_nxt.led_green   = (phase_nxt == rrs_pkg::PH_WAIT_G) ||
                                (phase_nxt == rrs_pkg::PH_READ_G);
      out_res_nxt.led_blue    = (phase_nxt == rrs_pkg::PH_WAIT_B) ||
                                (phase_nxt == rrs_pkg::PH_READ_B);
      out_res_nxt.done_res    = lvl_we && (ch_r == rrs_pkg::CH_BLUE);
      out_res_nxt.red_level   = red_nxt;
      out_res_nxt.green_level = green_nxt;
      out_res_nxt.blue_level  = blue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrs_pkg::BK_IDLE;
      phase_r     <= rrs_pkg::PH_IDLE;
      settle_r    <= '0;
      left_r      <= '0;
      sum_r       <= '0;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      ch_r        <= rrs_pkg::CH_RED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      settle_r    <= settle_nxt;
      left_r      <= left_nxt;
      sum_r       <= sum_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    avg_r     <= avg_nxt;
    if (take) begin
      item_r <= q_item;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !out_valid_r)
    else $error("result register overwritten");

  a_led_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_res_r.led_red, out_res_r.led_green,
                              out_res_r.led_blue}))
    else $error("more than one led on");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && out_res_nxt.done_res) |=> (phase_r == rrs_pkg::PH_IDLE))
    else $error("done raised outside idle");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (state_r == rrs_pkg::BK_AVG))
    else $error("divider started in wrong state");

endmodule

// File: rtl/rgb_reflectance_sequencer_top.sv
// ----------------------------------------------------------------------------
// rgb_reflectance_sequencer_top
// led-sequenced rgb reflectance sensor with two-point calibration
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in_       input      push / full        adc_sample, start_req, abort
// out_      output     pop / empty        led drives, done_res, three levels
// cfg_      input      cfg_we             cfg_idx, cfg_data
//
// a plain tick is taken from the queue, executed, and its result waits to be popped
// for the last sample of a channel the average is a shift and the calibration
// runs the 10-step divider; a flat or inverted window skips the divider
// reset is synchronous and needs no clearing pass
// a 2-deep input queue and a 1-entry result register decouple both sides;
// the back end takes no new tick while a result waits to be popped
// ----------------------------------------------------------------------------
module rgb_reflectance_sequencer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [rrs_pkg::SAMPLE_W-1:0]   in_adc_sample,
  input  logic                           in_start_req,
  input  logic                           in_abort,
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_led_red,
  output logic                           out_led_green,
  output logic                           out_led_blue,
  output logic                           out_done_res,
  output logic [rrs_pkg::LEVEL_W-1:0]    out_red_level,
  output logic [rrs_pkg::LEVEL_W-1:0]    out_green_level,
  output logic [rrs_pkg::LEVEL_W-1:0]    out_blue_level,
  input  logic                           cfg_we,
  input  logic [rrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rrs_pkg::CFG_W-1:0]      cfg_data
);

  rrs_pkg::cfg_t     cfg_r, cfg_nxt;
  logic              q_valid;
  rrs_pkg::item_t    q_item;
  logic              q_pop;
  logic              res_valid;
  rrs_pkg::result_t  res;
  logic [rrs_pkg::CAL_W-1:0] cal_val;

  assign cal_val = cfg_data[rrs_pkg::CAL_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        rrs_pkg::REG_SETTLE: cfg_nxt.settle_ticks = cfg_data[rrs_pkg::SETTLE_W-1:0];
        rrs_pkg::REG_LOW_R:  cfg_nxt.cal_low[0]   = cal_val;
        rrs_pkg::REG_HIGH_R: cfg_nxt.cal_high[0]  = cal_val;
        rrs_pkg::REG_LOW_G:  cfg_nxt.cal_low[1]   = cal_val;
        rrs_pkg::REG_HIGH_G: cfg_nxt.cal_high[1]  = cal_val;
        rrs_pkg::REG_LOW_B:  cfg_nxt.cal_low[2]   = cal_val;
        rrs_pkg::REG_HIGH_B: cfg_nxt.cal_high[2]  = cal_val;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks <= rrs_pkg::SETTLE_W'(10);
      cfg_r.cal_low      <= '0;
      cfg_r.cal_high     <= {3{rrs_pkg::CAL_W'(255)}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rrs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_adc_sample (in_adc_sample),
    .in_start_req  (in_start_req),
    .in_abort      (in_abort),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  rrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty           = !res_valid;
  assign out_led_red     = res.led_red;
  assign out_led_green   = res.led_green;
  assign out_led_blue    = res.led_blue;
  assign out_done_res    = res.done_res;
  assign out_red_level   = res.red_level;
  assign out_green_level = res.green_level;
  assign out_blue_level  = res.blue_level;

endmodule
